### hdl/obi_pkg.sv
// ----------------------------------------------------------------------------
// obi_pkg
// shared constants, types and the cordic arctangent table for the
// orientation bin interpolator
// ----------------------------------------------------------------------------
package obi_pkg;

  // histogram geometry
  localparam int NUM_BINS     = 9;
  localparam int BIN_IDX_BITS = 4;

  // cordic angle format: signed, units of pi / 2^ANG_FRAC_BITS
  localparam int ANG_FRAC_BITS     = 20;
  localparam int ANGLE_BITS        = 22;
  localparam int CORDIC_STEPS      = 20;
  localparam int PRESCALE_BITS     = 24;
  localparam int CORDIC_GUARD_BITS = 2;

  // orientation as a fraction of pi and the blend fraction
  localparam int FRAC_BITS = 16;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic [BIN_IDX_BITS-1:0]      bin_idx_t;
  typedef logic [FRAC_BITS-1:0]         frac_t;

  // 1.0 in blend fraction units
  localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // atan(2^-i) in units of pi / 2^20, rounded to nearest
  localparam angle_t ATAN_TAB [CORDIC_STEPS] = '{
    angle_t'(262144), angle_t'(154753), angle_t'(81767), angle_t'(41506),
    angle_t'(20834),  angle_t'(10427),  angle_t'(5215),  angle_t'(2608),
    angle_t'(1304),   angle_t'(652),    angle_t'(326),   angle_t'(163),
    angle_t'(81),     angle_t'(41),     angle_t'(20),    angle_t'(10),
    angle_t'(5),      angle_t'(3),      angle_t'(1),     angle_t'(1)
  };

endpackage

### hdl/obi_cordic_step.sv
// ----------------------------------------------------------------------------
// obi_cordic_step
// one registered vectoring iteration of the cordic angle unit
// ----------------------------------------------------------------------------
module obi_cordic_step #(
  parameter int DATA_BITS = 43,
  parameter int STEP      = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [DATA_BITS-1:0] cx_in,
  input  logic signed [DATA_BITS-1:0] cy_in,
  input  obi_pkg::angle_t             z_in,
  output logic signed [DATA_BITS-1:0] cx_out,
  output logic signed [DATA_BITS-1:0] cy_out,
  output obi_pkg::angle_t             z_out
);
  import obi_pkg::*;

  logic signed [DATA_BITS-1:0] dx;
  logic signed [DATA_BITS-1:0] dy;
  logic                        rot_pos;

  // floor shifts of the old values
  assign dx      = cy_in >>> STEP;
  assign dy      = cx_in >>> STEP;
  assign rot_pos = (cy_in > 0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (rot_pos) begin
        cx_out <= cx_in + dx;
        cy_out <= cy_in - dy;
        z_out  <= z_in + ATAN_TAB[STEP];
      end else begin
        cx_out <= cx_in - dx;
        cy_out <= cy_in + dy;
        z_out  <= z_in - ATAN_TAB[STEP];
      end
    end
  end

endmodule

### hdl/orientation_bin_interpolator.sv
// ----------------------------------------------------------------------------
// orientation_bin_interpolator
// blends the two histogram bin weights on either side of a vector's
// undirected orientation
// ----------------------------------------------------------------------------
// usage:
//   the s_axis channel carries one item per histogram cell: the direction
//   vector (x, y) and the nine bin weights. the m_axis channel returns one
//   item per input item: the blended weight in tdata and the zero vector
//   flag in tuser
//   the orientation is found by a 20-step cordic, one iteration per stage,
//   followed by bin selection, two multiplies and the final add
//   pipeline: each item passes the input stage, 20 cordic stages, bin
//   stage, select stage, multiply stage and output register
//   throughput: one item per cycle while the output is not stalled, every stage is one register deep
//   reset: all valid bits clear, the pipeline is empty and s_axis_tready
//   is high on the first cycle after reset
//   stall: when m_axis_tready is low with a result waiting, the whole
//   pipeline holds and s_axis_tready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module orientation_bin_interpolator #(
  parameter int VECTOR_BITS = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // vec_x, vec_y, weight_bin0 .. weight_bin8, zero padded to whole bytes
  input  logic [((2*VECTOR_BITS + obi_pkg::NUM_BINS*WEIGHT_BITS + 7) / 8) * 8 - 1:0]
               s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // blended_weight, zero padded to whole bytes
  output logic [((WEIGHT_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // zero_vector
  output logic m_axis_tuser
);
  import obi_pkg::*;

  localparam int OUT_BITS  = ((WEIGHT_BITS + 7) / 8) * 8;
  localparam int EXT_BITS  = VECTOR_BITS + 1;
  localparam int CW        = EXT_BITS + PRESCALE_BITS + CORDIC_GUARD_BITS;
  localparam int POS_BITS  = FRAC_BITS + BIN_IDX_BITS;
  localparam int PROD_BITS = WEIGHT_BITS + FRAC_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 1;

  typedef logic [NUM_BINS-1:0][WEIGHT_BITS-1:0] weights_t;

  // pipeline advance: everything moves unless a result waits unaccepted
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // input decode and quadrant folding
  // --------------------------------------------------------------------------
  logic signed [EXT_BITS-1:0] in_x, in_y, neg_x, neg_y;
  logic signed [EXT_BITS-1:0] px, py, neg_py;
  logic signed [EXT_BITS-1:0] cx0, cy0;
  logic                       x_neg, py_neg, in_zero, in_xzero;
  weights_t                   in_w;

  always_comb begin
    in_x  = {s_axis_tdata[VECTOR_BITS-1], s_axis_tdata[VECTOR_BITS-1:0]};
    in_y  = {s_axis_tdata[2*VECTOR_BITS-1], s_axis_tdata[2*VECTOR_BITS-1:VECTOR_BITS]};
    neg_x = -in_x;
    neg_y = -in_y;
    x_neg = in_x[EXT_BITS-1];
    // turn the vector so x is not negative
    px     = x_neg ? neg_x : in_x;
    py     = x_neg ? neg_y : in_y;
    neg_py = x_neg ? in_y : neg_y;
    py_neg = py[EXT_BITS-1];
    // lower half plane starts half of pi further on
    if (!py_neg) begin
      cx0 = py;
      cy0 = px;
    end else begin
      cx0 = px;
      cy0 = neg_py;
    end
    in_zero  = (in_x == '0) && (in_y == '0);
    in_xzero = (in_x == '0);
    for (int k = 0; k < NUM_BINS; k++) begin
      in_w[k] = s_axis_tdata[2*VECTOR_BITS + k*WEIGHT_BITS +: WEIGHT_BITS];
    end
  end

  // --------------------------------------------------------------------------
  // cordic pipeline; index 0 is the input stage
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] cx   [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy   [CORDIC_STEPS+1];
  angle_t               z    [CORDIC_STEPS+1];
  logic                 vld  [CORDIC_STEPS+1];
  logic                 zero [CORDIC_STEPS+1];
  logic                 xzero[CORDIC_STEPS+1];
  weights_t             wts  [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]    <= {{CORDIC_GUARD_BITS{cx0[EXT_BITS-1]}}, cx0, {PRESCALE_BITS{1'b0}}};
      cy[0]    <= {{CORDIC_GUARD_BITS{cy0[EXT_BITS-1]}}, cy0, {PRESCALE_BITS{1'b0}}};
      // quadrant base folded into the starting angle
      z[0]     <= py_neg ? angle_t'(1 << (ANG_FRAC_BITS - 1)) : '0;
      zero[0]  <= in_zero;
      xzero[0] <= in_xzero;
      wts[0]   <= in_w;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    obi_cordic_step #(
      .DATA_BITS (CW),
      .STEP      (k)
    ) u_step (
      .clk    (clk),
      .en     (en),
      .cx_in  (cx[k]),
      .cy_in  (cy[k]),
      .z_in   (z[k]),
      .cx_out (cx[k+1]),
      .cy_out (cy[k+1]),
      .z_out  (z[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    // side band travels alongside the angle
    always_ff @(posedge clk) begin
      if (en) begin
        zero[k+1]  <= zero[k];
        xzero[k+1] <= xzero[k];
        wts[k+1]   <= wts[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // angle clamp and bin position
  // --------------------------------------------------------------------------
  angle_t                     z_fin;
  logic [ANG_FRAC_BITS-1:0]   ang_full;
  frac_t                      ang;
  logic [POS_BITS-1:0]        pos;
  bin_idx_t                   left_raw;

  always_comb begin
    z_fin = z[CORDIC_STEPS];
    if (z_fin[ANGLE_BITS-1]) begin
      ang_full = '0;
    end else if (|z_fin[ANGLE_BITS-2:ANG_FRAC_BITS]) begin
      // at or past pi: largest angle below pi
      ang_full = '1;
    end else begin
      ang_full = z_fin[ANG_FRAC_BITS-1:0];
    end
    // vector on the y axis has orientation zero
    ang      = xzero[CORDIC_STEPS] ? '0 : ang_full[ANG_FRAC_BITS-1 -: FRAC_BITS];
    pos      = POS_BITS'(ang) * POS_BITS'(NUM_BINS);
    left_raw = pos[POS_BITS-1:FRAC_BITS];
  end

  logic     a_valid, a_zero;
  bin_idx_t a_left;
  frac_t    a_r;
  weights_t a_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_left <= (left_raw >= bin_idx_t'(NUM_BINS)) ? bin_idx_t'(NUM_BINS - 1) : left_raw;
      a_r    <= pos[FRAC_BITS-1:0];
      a_zero <= zero[CORDIC_STEPS];
      a_w    <= wts[CORDIC_STEPS];
    end
  end

  // --------------------------------------------------------------------------
  // neighbor bin selection
  // --------------------------------------------------------------------------
  bin_idx_t a_right;
  assign a_right = (a_left == bin_idx_t'(NUM_BINS - 1)) ? '0 : a_left + 1'b1;

  logic                   b_valid, b_zero;
  logic [WEIGHT_BITS-1:0] b_wl, b_wr;
  frac_t                  b_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_wl   <= a_w[a_left];
      b_wr   <= a_w[a_right];
      b_r    <= a_r;
      b_zero <= a_zero;
    end
  end

  // --------------------------------------------------------------------------
  // blend products
  // --------------------------------------------------------------------------
  logic                 c_valid, c_zero;
  logic [PROD_BITS-1:0] c_pl, c_pr;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_pl   <= PROD_BITS'(b_wl) * PROD_BITS'(FRAC_ONE - {1'b0, b_r});
      c_pr   <= PROD_BITS'(b_wr) * PROD_BITS'(b_r);
      c_zero <= b_zero;
    end
  end

  // --------------------------------------------------------------------------
  // sum, truncate and output register
  // --------------------------------------------------------------------------
  logic [SUM_BITS-1:0]    sum;
  logic [WEIGHT_BITS-1:0] blended;

  assign sum     = SUM_BITS'(c_pl) + SUM_BITS'(c_pr);
  assign blended = c_zero ? '0 : sum[FRAC_BITS +: WEIGHT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= OUT_BITS'(blended);
      m_axis_tuser <= c_zero;
    end
  end

endmodule

### tb/tb_orientation_bin_interpolator.sv
// ----------------------------------------------------------------------------
// tb_orientation_bin_interpolator
// self-checking stream testbench: every accepted item is run through a
// software cordic and bin blend, and each returned item is compared with
// the oldest prediction while both stream sides idle and stall at random
// ----------------------------------------------------------------------------
module tb_orientation_bin_interpolator;

  localparam int VEC_W    = 16;
  localparam int WGT_W    = 16;
  localparam int BINS     = obi_pkg::NUM_BINS;
  localparam int IN_W     = ((2*VEC_W + BINS*WGT_W + 7) / 8) * 8;
  localparam int OUT_W    = ((WGT_W + 7) / 8) * 8;
  // base wait before the final check for stray results
  localparam int LATENCY  = 24;
  localparam int HOLD_LEN = 300;

  // cordic constants, atan(2^-i) in units of pi / 2^20
  localparam int ANG_BITS   = 20;
  localparam int ITERATIONS = 20;
  localparam int PRESCALE   = 24;
  localparam longint ATAN_STEP [ITERATIONS] = '{
    262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
    1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
  };

  typedef struct packed {
    logic [BINS-1:0][WGT_W-1:0] w;
    logic signed [VEC_W-1:0]    vy;
    logic signed [VEC_W-1:0]    vx;
  } hist_item_t;

  typedef struct packed {
    logic [WGT_W-1:0] blended;
    logic             zero_flag;
  } blend_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  // shared between the stimulus and the receiver
  blend_t pending_blends [$];
  logic   quiet_mode = 1'b0;
  int     hold_request = 0;
  int     errors = 0;
  int     items_sent = 0;
  int     results_seen = 0;
  int     zero_results = 0;

  orientation_bin_interpolator #(
    .VECTOR_BITS(VEC_W),
    .WEIGHT_BITS(WGT_W)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    // vec_x, vec_y, weight_bin0 .. weight_bin8
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    // blended_weight
    .m_axis_tdata (m_axis_tdata),
    // zero_vector
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(12 * 300000);
    $display("FAIL orientation_bin_interpolator");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // undirected orientation as a 16-bit fraction of pi, x nonzero
  function automatic logic [15:0] orient_frac(input longint x, input longint y);
    longint px, py, cx, cy, dx, dy, z, base, total;
    px = x;
    py = y;
    z = 0;
    base = 0;
    // turn the vector so x is not negative
    if (px < 0) begin
      px = -px;
      py = -py;
    end
    // rotate into the first quadrant, remembering a half-pi base
    if (py >= 0) begin
      cx = py;
      cy = px;
    end else begin
      base = longint'(1) <<< (ANG_BITS - 1);
      cx = px;
      cy = -py;
    end
    cx = cx <<< PRESCALE;
    cy = cy <<< PRESCALE;
    for (int i = 0; i < ITERATIONS; i++) begin
      // arithmetic shift on signed values is a floor shift
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx = cx + dx;
        cy = cy - dy;
        z = z + ATAN_STEP[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z = z - ATAN_STEP[i];
      end
    end
    total = base + z;
    if (total < 0) total = 0;
    if (total > (longint'(1) <<< ANG_BITS) - 1) total = (longint'(1) <<< ANG_BITS) - 1;
    return total[ANG_BITS-1 -: 16];
  endfunction

  function automatic blend_t predict_blend(input hist_item_t it);
    blend_t res;
    longint x, y, pos, left, right, r, wl, wr, sum;
    logic [15:0] a;
    x = longint'(it.vx);
    y = longint'(it.vy);
    if (x == 0 && y == 0) begin
      res.blended = '0;
      res.zero_flag = 1'b1;
      return res;
    end
    // on the y axis the orientation is exactly zero
    a = (x == 0) ? 16'd0 : orient_frac(x, y);
    pos = longint'(a) * BINS;
    left = pos >> 16;
    r = pos & 16'hFFFF;
    if (left >= BINS) left = BINS - 1;
    right = (left + 1 >= BINS) ? 0 : left + 1;
    wl = longint'(it.w[left]);
    wr = longint'(it.w[right]);
    sum = wl * (65536 - r) + wr * r;
    res.blended = WGT_W'(sum >> 16);
    res.zero_flag = 1'b0;
    return res;
  endfunction

  function automatic hist_item_t make_item(input int x, input int y, input int w_base,
                                           input int w_step);
    hist_item_t it;
    it.vx = VEC_W'(x);
    it.vy = VEC_W'(y);
    for (int k = 0; k < BINS; k++) it.w[k] = WGT_W'(w_base + k * w_step);
    return it;
  endfunction

  function automatic hist_item_t random_item();
    hist_item_t it;
    int sel, wsel;
    sel = $urandom_range(99);
    wsel = $urandom_range(99);
    if (sel < 60) begin
      it.vx = VEC_W'($urandom);
      it.vy = VEC_W'($urandom);
    end else if (sel < 75) begin
      // short vectors where the cordic has little to work with
      it.vx = VEC_W'($urandom_range(8) - 4);
      it.vy = VEC_W'($urandom_range(8) - 4);
    end else if (sel < 85) begin
      // on an axis
      if ($urandom_range(1)) begin
        it.vx = '0;
        it.vy = VEC_W'($urandom);
      end else begin
        it.vx = VEC_W'($urandom);
        it.vy = '0;
      end
    end else if (sel < 90) begin
      it.vx = '0;
      it.vy = '0;
    end else begin
      // orientation at or just below pi
      it.vx = VEC_W'($urandom_range(8) + 1);
      it.vy = VEC_W'(-int'($urandom_range(32768, 16000)));
      if ($urandom_range(1)) begin
        it.vx = -it.vx;
        it.vy = -it.vy;
      end
    end
    for (int k = 0; k < BINS; k++) begin
      if (wsel < 5) it.w[k] = '1;
      else if (wsel < 10) it.w[k] = '0;
      else it.w[k] = WGT_W'($urandom);
    end
    return it;
  endfunction

  // offer one item, with a random gap in front of it unless quiet
  task automatic send_item(input hist_item_t it);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 6) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'(it);
    do @(posedge clk); while (!s_axis_tready);
    pending_blends.insert(pending_blends.size(), predict_blend(it));
    items_sent++;
  endtask

  // sender pauses until every predicted result has come back
  task automatic await_drain();
    s_tvalid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, a counted long hold-off, and the result check
  always @(posedge clk) begin : receiver
    static int stall_left = 0;
    blend_t want;
    if (hold_request != 0) begin
      stall_left = hold_request;
      hold_request <= 0;
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!quiet_mode && $urandom_range(99) < 6) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
    if (!rst && m_axis_tvalid && m_tready) begin
      results_seen++;
      if (m_axis_tuser) zero_results++;
      if (pending_blends.size() == 0) begin
        report_mismatch($sformatf("result %0h/%0b with nothing outstanding",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_blends.pop_front();
        if (m_axis_tdata[WGT_W-1:0] !== want.blended)
          report_mismatch($sformatf("result %0d blended_weight got %0h want %0h",
                                    results_seen, m_axis_tdata[WGT_W-1:0], want.blended));
        if (m_axis_tuser !== want.zero_flag)
          report_mismatch($sformatf("result %0d zero_vector got %0b want %0b",
                                    results_seen, m_axis_tuser, want.zero_flag));
      end
    end
  end

  // field extremes, bin wrap and the fold near pi
  task automatic test_directed_extremes();
    send_item(make_item(32767, 32767, 1000, 3000));
    send_item(make_item(-32768, -32768, 1000, 3000));
    send_item(make_item(32767, -32768, 0, 7000));
    send_item(make_item(-32768, 32767, 65535, -7000));
    send_item(make_item(-32768, 0, 100, 8000));
    send_item(make_item(32767, 0, 100, 8000));
    send_item(make_item(1, 0, 5, 0));
    send_item(make_item(-1, 0, 65535, 0));
    // nearly straight down after the fold, orientation right under pi
    send_item(make_item(1, -32768, 2000, 7000));
    send_item(make_item(-1, 32767, 2000, 7000));
    send_item(make_item(1, -1, 0, 8191));
    send_item(make_item(1, 1, 65535, -8191));
    send_item(make_item(-1, -1, 0, 0));
    send_item(make_item(12345, -321, 65535, 0));
    await_drain();
  endtask

  // zero vector and vectors on the y axis
  task automatic test_axis_and_zero();
    send_item(make_item(0, 0, 65535, 0));
    send_item(make_item(0, 0, 1234, 111));
    send_item(make_item(0, 1, 777, 5000));
    send_item(make_item(0, 32767, 65535, -100));
    send_item(make_item(0, -32768, 42, 3));
    send_item(make_item(0, -1, 0, 4096));
    send_item(make_item(0, 0, 0, 0));
    await_drain();
  endtask

  // long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure_fill();
    quiet_mode <= 1'b1;
    hold_request <= HOLD_LEN;
    for (int n = 0; n < 80; n++) send_item(random_item());
    await_drain();
    quiet_mode <= 1'b0;
  endtask

  // random stream: a stretch with no idling, then idling on both sides
  task automatic test_random_stream();
    quiet_mode <= 1'b1;
    for (int n = 0; n < 150; n++) send_item(random_item());
    quiet_mode <= 1'b0;
    for (int n = 0; n < 270; n++) begin
      send_item(random_item());
      if (n % 90 == 89) await_drain();
    end
    await_drain();
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    test_axis_and_zero();
    test_backpressure_fill();
    test_random_stream();

    // let the pipeline empty, then watch for stray results
    s_tvalid <= 1'b0;
    for (int n = 0; n < 4000 && pending_blends.size() != 0; n++) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
    if (pending_blends.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_blends.size()));

    $display("covered %0d items, %0d results checked (%0d zero vectors)",
             items_sent, results_seen, zero_results);
    $display("with random gaps, a %0d-cycle output hold-off and drained pauses",
             HOLD_LEN);
    if (errors == 0) begin
      $display("PASS orientation_bin_interpolator");
    end else begin
      $display("FAIL orientation_bin_interpolator");
    end
    $finish;
  end

endmodule
